// File: hw/rtl/mhfp_pkg.sv
// ----------------------------------------------------------------------------
// mhfp_pkg
// Types, constants and name tables of the mail header field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mhfp_pkg;

  localparam int unsigned MaxLineDef  = 512;
  localparam int unsigned FoldLimitDef = 511;
  localparam int unsigned MaxNameDef  = 32;

  localparam int unsigned NNames   = 23;
  localparam int unsigned EnvIndex = 23;
  localparam int unsigned NameLen  = 25;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_EOI   = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FEND   = 2'd1,
    KIND_HEND   = 2'd2,
    KIND_HERR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    M_NAME        = 3'd0,
    M_NAME_STRIP  = 3'd1,
    M_VALSKIP     = 3'd2,
    M_VALUE       = 3'd3,
    M_VALUE_STRIP = 3'd4,
    M_ENVSKIP     = 3'd5,
    M_ENVWORD     = 3'd6,
    M_IGNORE      = 3'd7
  } mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] field_index;
    logic [7:0] value_byte;
  } res_t;

  // Up to two results per item.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } pair_t;

  function automatic logic [4:0] name_len(input logic [4:0] i);
    logic [4:0] l;
    unique case (i)
      5'd0: l = 5'd8;   5'd1: l = 5'd2;   5'd2: l = 5'd14;  5'd3: l = 5'd25;
      5'd4: l = 5'd12;  5'd5: l = 5'd4;   5'd6: l = 5'd12;  5'd7: l = 5'd7;
      5'd8: l = 5'd11;  5'd9: l = 5'd4;   5'd10: l = 5'd8;  5'd11: l = 5'd10;
      5'd12: l = 5'd12; 5'd13: l = 5'd10; 5'd14: l = 5'd12; 5'd15: l = 5'd10;
      5'd16: l = 5'd10; 5'd17: l = 5'd8;  5'd18: l = 5'd11; 5'd19: l = 5'd6;
      5'd20: l = 5'd7;  5'd21: l = 5'd7;  5'd22: l = 5'd2;
      default: l = 5'd0;
    endcase
    return l;
  endfunction

  function automatic logic [NameLen*8-1:0] name_str(input logic [4:0] i);
    logic [NameLen*8-1:0] s;
    unique case (i)
      5'd0:  s = (NameLen*8)'("approved");
      5'd1:  s = (NameLen*8)'("cc");
      5'd2:  s = (NameLen*8)'("content-length");
      5'd3:  s = (NameLen*8)'("content-transfer-encoding");
      5'd4:  s = (NameLen*8)'("content-type");
      5'd5:  s = (NameLen*8)'("date");
      5'd6:  s = (NameLen*8)'("distribution");
      5'd7:  s = (NameLen*8)'("expires");
      5'd8:  s = (NameLen*8)'("followup-to");
      5'd9:  s = (NameLen*8)'("from");
      5'd10: s = (NameLen*8)'("keywords");
      5'd11: s = (NameLen*8)'("message-id");
      5'd12: s = (NameLen*8)'("mime-version");
      5'd13: s = (NameLen*8)'("newsgroups");
      5'd14: s = (NameLen*8)'("organization");
      5'd15: s = (NameLen*8)'("supersedes");
      5'd16: s = (NameLen*8)'("references");
      5'd17: s = (NameLen*8)'("reply-to");
      5'd18: s = (NameLen*8)'("resent-from");
      5'd19: s = (NameLen*8)'("sender");
      5'd20: s = (NameLen*8)'("subject");
      5'd21: s = (NameLen*8)'("summary");
      5'd22: s = (NameLen*8)'("to");
      default: s = '0;
    endcase
    return s;
  endfunction

  // Character at position p of name i; strings are right-aligned, so the
  // first character sits at byte (len-1).
  function automatic logic [7:0] name_chr(input logic [4:0] i, input logic [4:0] p);
    logic [NameLen*8-1:0] s;
    logic [4:0] l;
    logic [4:0] k;
    s = name_str(i);
    l = name_len(i);
    k = l - 5'd1 - p;
    return s[k*8 +: 8];
  endfunction

  function automatic logic [7:0] env_chr(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0: c = "F"; 3'd1: c = "r"; 3'd2: c = "o"; 3'd3: c = "m";
      default: c = " ";
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mhfp_if.sv
// ----------------------------------------------------------------------------
// mhfp_in_if / mhfp_out_if
// Valid/ready channels of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhfp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface mhfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] field_index;
  logic [7:0] value_byte;
  modport source (output valid, kind, field_index, value_byte, input ready);
  modport sink   (input valid, kind, field_index, value_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mhfp_front.sv
// ----------------------------------------------------------------------------
// mhfp_front
// Parser state machine: takes one byte per cycle while go_i is high, produces 0..2 results.
// ----------------------------------------------------------------------------
`default_nettype none

module mhfp_front #(
  parameter int unsigned MaxLine   = mhfp_pkg::MaxLineDef,
  parameter int unsigned FoldLimit = mhfp_pkg::FoldLimitDef,
  parameter int unsigned MaxName   = mhfp_pkg::MaxNameDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           go_i,
  input  wire logic [1:0]     cmd_i,
  input  wire logic [7:0]     byte_i,
  output mhfp_pkg::pair_t     pair_o
);
  import mhfp_pkg::*;

  localparam int unsigned LW = $clog2(MaxLine + 1);
  localparam int unsigned FW = $clog2(FoldLimit + 1);
  localparam int unsigned NW = $clog2(MaxName + 1);

  mode_e        mode_q, mode_d;
  logic         ls_q, ls_d;
  logic [23:0]  cand_q, cand_d;
  logic [NW-1:0] pos_q, pos_d;
  logic [4:0]   fld_q, fld_d;
  logic         vs_q, vs_d;
  logic [LW-1:0] llen_q, llen_d;
  logic [FW-1:0] flen_q, flen_d;
  logic         done_q, done_d;
  pair_t        pr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NAME; ls_q <= 1'b1; cand_q <= '1; pos_q <= '0; fld_q <= '0;
      vs_q <= 1'b0; llen_q <= '0; flen_q <= '0; done_q <= 1'b0;
    end else if (go_i) begin
      mode_q <= mode_d; ls_q <= ls_d; cand_q <= cand_d; pos_q <= pos_d;
      fld_q <= fld_d; vs_q <= vs_d; llen_q <= llen_d; flen_q <= flen_d;
      done_q <= done_d;
    end
  end

  always_comb begin
    logic       blank, do_join, do_name, do_colon, found;
    logic [7:0] c, nc, lc;
    logic [23:0] keep;
    logic [NW-1:0] npos;
    mode_e      m;
    res_t       e;
    mode_d = mode_q; ls_d = ls_q; cand_d = cand_q; pos_d = pos_q; fld_d = fld_q;
    vs_d = vs_q; llen_d = llen_q; flen_d = flen_q; done_d = done_q;
    pr = '0;
    c = byte_i;
    blank = (c == " ") || (c == 8'h09);
    do_join = 1'b0; do_name = 1'b0; do_colon = 1'b0; found = 1'b0;
    nc = c; keep = '0; npos = pos_q; m = mode_q; e = '0;

    priority if (cmd_i == CMD_START) begin
      mode_d = M_NAME; ls_d = 1'b1; cand_d = '1; pos_d = '0; fld_d = '0;
      vs_d = 1'b0; llen_d = '0; flen_d = '0; done_d = 1'b0;
    end else if (cmd_i == CMD_NOP || done_q) begin
    end else if (cmd_i == CMD_EOI || (ls_q && c == 8'h0a)) begin
      if (vs_q) begin
        pr.r0 = '{kind: KIND_FEND, field_index: fld_q, value_byte: 8'd0};
        pr.r1 = '{kind: KIND_HEND, field_index: 5'd0, value_byte: 8'd0};
        pr.n = 2'd2;
      end else begin
        pr.r0 = '{kind: KIND_HEND, field_index: 5'd0, value_byte: 8'd0};
        pr.n = 2'd1;
      end
      done_d = 1'b1;
    end else if (ls_q && blank &&
                 !(mode_q == M_NAME && flen_q == '0)) begin
      // continuation line: join space
      ls_d = 1'b0; llen_d = '0;
      if (flen_q < FW'(FoldLimit)) begin
        flen_d = flen_q + 1'b1;
        unique case (mode_q)
          M_NAME, M_NAME_STRIP: begin
            do_name = 1'b1; do_join = 1'b1; nc = " ";
          end
          M_VALUE, M_VALUE_STRIP: begin
            pr.r0 = '{kind: KIND_BYTE, field_index: fld_q, value_byte: " "};
            pr.n = 2'd1; vs_d = 1'b1; mode_d = M_VALUE_STRIP;
          end
          M_ENVWORD: mode_d = M_IGNORE;
          default: ;
        endcase
      end
    end else begin
      // ordinary byte; the first byte of a new line closes the previous field
      m = mode_q;
      if (ls_q) begin
        if (vs_q) begin
          pr.r0 = '{kind: KIND_FEND, field_index: fld_q, value_byte: 8'd0};
          pr.n = 2'd1;
        end
        cand_d = '1; pos_d = '0; fld_d = '0; vs_d = 1'b0; flen_d = '0;
        m = M_NAME; mode_d = M_NAME; llen_d = '0;
      end
      if (c == 8'h0a) begin
        ls_d = 1'b1;
      end else begin
        ls_d = 1'b0;
        llen_d = (ls_q ? LW'(0) : llen_q) + 1'b1;
        if (llen_d >= LW'(MaxLine - 2)) begin
          if (vs_d) begin
            e = '{kind: KIND_FEND, field_index: fld_d, value_byte: 8'd0};
            if (pr.n == 2'd0) pr.r0 = e; else pr.r1 = e;
            pr.n = pr.n + 2'd1;
          end
          e = '{kind: KIND_HERR, field_index: 5'd0, value_byte: 8'd0};
          if (pr.n == 2'd0) pr.r0 = e; else pr.r1 = e;
          pr.n = pr.n + 2'd1;
          done_d = 1'b1;
          cand_d = '1; pos_d = '0; fld_d = '0; vs_d = 1'b0; flen_d = '0;
        end else if (!((m == M_NAME_STRIP || m == M_VALUE_STRIP) && blank) &&
                     flen_d < FW'(FoldLimit)) begin
          flen_d = flen_d + 1'b1;
          if (m == M_NAME_STRIP) m = M_NAME;
          if (m == M_VALUE_STRIP) m = M_VALUE;
          mode_d = m;
          e = '{kind: KIND_BYTE, field_index: fld_d, value_byte: c};
          unique case (m)
            M_NAME: if (c == ":") do_colon = 1'b1; else do_name = 1'b1;
            M_VALSKIP, M_ENVSKIP: if (!blank) begin
              pr.r1 = e; if (pr.n == 2'd0) pr.r0 = e;
              pr.n = pr.n + 2'd1; vs_d = 1'b1;
              mode_d = (m == M_VALSKIP) ? M_VALUE : M_ENVWORD;
            end
            M_VALUE: begin
              pr.r1 = e; if (pr.n == 2'd0) pr.r0 = e;
              pr.n = pr.n + 2'd1; vs_d = 1'b1;
            end
            M_ENVWORD: if (c == " ") mode_d = M_IGNORE;
              else begin
                pr.r1 = e; if (pr.n == 2'd0) pr.r0 = e;
                pr.n = pr.n + 2'd1; vs_d = 1'b1;
              end
            default: ;
          endcase
        end
      end
    end

    // incremental name match on the candidate mask
    lc = (nc >= "A" && nc <= "Z") ? nc + 8'd32 : nc;
    for (int i = 0; i < 23; i++) begin
      keep[i] = cand_d[i] && (pos_d < NW'(name_len(5'(i)))) &&
                (name_chr(5'(i), 5'(pos_d)) == lc);
    end
    keep[23] = cand_d[23] && (pos_d < NW'(5)) && (env_chr(3'(pos_d)) == nc);
    npos = (pos_d < NW'(MaxName)) ? pos_d + 1'b1 : pos_d;
    if (do_name) begin
      cand_d = keep; pos_d = npos;
      if (keep[23] && npos == NW'(5)) begin
        mode_d = M_ENVSKIP; fld_d = 5'(EnvIndex);
      end else if (do_join) begin
        // folded name: skip the blanks that follow the join space
        mode_d = M_NAME_STRIP;
      end
    end
    if (do_colon) begin
      mode_d = M_IGNORE;
      for (int i = 22; i >= 0; i--) begin
        if (cand_d[i] && NW'(name_len(5'(i))) == pos_d) begin
          found = 1'b1; fld_d = 5'(i);
        end
      end
      if (found) mode_d = M_VALSKIP;
    end
  end

  assign pair_o = pr;

endmodule

`default_nettype wire

// File: hw/rtl/mhfp_back.sv
// ----------------------------------------------------------------------------
// mhfp_back
// Result queue: holds results and drains them one item per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mhfp_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire mhfp_pkg::pair_t pair_i,
  output logic             room_o,
  mhfp_out_if.source       out
);
  import mhfp_pkg::*;

  localparam int unsigned Depth = 4;

  res_t       mem_q [Depth];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] n;

  assign n = push_i ? pair_i.n : 2'd0;
  assign pop = out.valid && out.ready;
  assign out.valid = cnt_q != 3'd0;
  assign out.kind = mem_q[rp_q].kind;
  assign out.field_index = mem_q[rp_q].field_index;
  assign out.value_byte = mem_q[rp_q].value_byte;
  assign room_o = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (n != 2'd0) mem_q[wp_q] <= pair_i.r0;
    if (n == 2'd2) mem_q[wp_q + 2'd1] <= pair_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_q + n;
      rp_q <= rp_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n} - {2'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n != 2'd0) |-> (cnt_q <= 3'd2)) else $error("push without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 3'd0 && n == 2'd0) |=> !out.valid) else $error("phantom item");

endmodule

`default_nettype wire

// File: hw/rtl/mail_header_field_parser_core.sv
// ----------------------------------------------------------------------------
// mail_header_field_parser_core
// Streaming RFC-822 style header parser, one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Throughput: one input item per cycle while the result queue has room.
// Results of an input item are written into the registered queue when the item is taken.
// An item may make two results; the 4-entry queue drains one per cycle while out.ready is high.
// Reset: rst_ni clears parser state to line start and empties the queue.
`default_nettype none

module mail_header_field_parser_core #(
  parameter int unsigned MaxLine   = mhfp_pkg::MaxLineDef,
  parameter int unsigned FoldLimit = mhfp_pkg::FoldLimitDef,
  parameter int unsigned MaxName   = mhfp_pkg::MaxNameDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mhfp_in_if.sink    in,
  mhfp_out_if.source out
);
  import mhfp_pkg::*;

  pair_t pair;
  logic  room, go;

  // Front parser advances only when the queue can take two more items.
  assign in.ready = room;
  assign go = in.valid && room;

  mhfp_front #(.MaxLine(MaxLine), .FoldLimit(FoldLimit), .MaxName(MaxName)) u_front (
    .clk_i, .rst_ni, .go_i(go), .cmd_i(in.cmd), .byte_i(in.data_byte), .pair_o(pair)
  );

  mhfp_back u_back (
    .clk_i, .rst_ni, .push_i(go), .pair_i(pair), .room_o(room), .out(out)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of mail_header_field_parser_core. A queue of header items built
// by directed and random message generators feeds a bursty driver. A
// item-level model of the parser predicts the results. A stalling monitor
// compares each result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mhfp_pkg::*;

  localparam int unsigned MaxLine   = MaxLineDef;
  localparam int unsigned FoldLimit = FoldLimitDef;
  localparam int unsigned MaxName   = MaxNameDef;
  localparam int          IdleLimit = 20000;
  localparam int          RandItems = 1300;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
    bit         hold;   // wait for every result to drain before this item
  } hdr_item_t;

  logic clk_i;
  logic rst_ni;

  mhfp_in_if  in_if ();
  mhfp_out_if out_if ();

  mail_header_field_parser_core #(
    .MaxLine  (MaxLine),
    .FoldLimit(FoldLimit),
    .MaxName  (MaxName)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in    (in_if.sink),
    .out   (out_if.source)
  );

  always begin
    clk_i = 1'b0; #2;
    clk_i = 1'b1; #2;
  end

  // --------------------------------------------------------------------------
  // Parser model state
  // --------------------------------------------------------------------------
  string known_tab [NNames] = '{
    "approved", "cc", "content-length", "content-transfer-encoding",
    "content-type", "date", "distribution", "expires", "followup-to",
    "from", "keywords", "message-id", "mime-version", "newsgroups",
    "organization", "supersedes", "references", "reply-to", "resent-from",
    "sender", "subject", "summary", "to"
  };
  string env_text = "From ";

  bit          at_line_start;
  mode_e       fmode;
  logic [23:0] cand;
  int unsigned npos;
  logic [4:0]  cur_field;
  bit          val_started;
  int unsigned line_len;
  int unsigned field_len;
  bit          hdr_done;

  res_t        exp_results[$];
  hdr_item_t   pend_items[$];

  int          mismatches;

  task automatic push_result(input kind_e k, input logic [4:0] fi, input logic [7:0] vb);
    res_t r;
    r.kind = k;
    r.field_index = fi;
    r.value_byte = vb;
    exp_results.push_back(r);
  endtask

  task automatic clear_field();
    cand        = '1;
    npos        = 0;
    cur_field   = '0;
    val_started = 1'b0;
    field_len   = 0;
  endtask

  task automatic parser_reset();
    at_line_start = 1'b1;
    fmode         = M_NAME;
    clear_field();
    line_len = 0;
    hdr_done = 1'b0;
  endtask

  task automatic close_field();
    if (val_started) push_result(KIND_FEND, cur_field, 8'd0);
    clear_field();
  endtask

  task automatic value_out(input logic [7:0] c);
    push_result(KIND_BYTE, cur_field, c);
    val_started = 1'b1;
  endtask

  // Incremental name match: narrow the candidate set by one character.
  task automatic match_char(input logic [7:0] c);
    logic [7:0]  lc;
    logic [23:0] keep;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    keep = '0;
    for (int i = 0; i < NNames; i++)
      if (cand[i] && npos < known_tab[i].len() && known_tab[i][npos] == lc)
        keep[i] = 1'b1;
    if (cand[23] && npos < 5 && env_text[npos] == c) keep[23] = 1'b1;
    cand = keep;
    if (npos < MaxName) npos++;
    if (cand[23] && npos == 5) begin
      fmode     = M_ENVSKIP;
      cur_field = 5'(EnvIndex);
    end
  endtask

  task automatic match_colon();
    for (int i = 0; i < NNames; i++)
      if (cand[i] && known_tab[i].len() == npos) begin
        cur_field = 5'(i);
        fmode     = M_VALSKIP;
        return;
      end
    fmode = M_IGNORE;
  endtask

  task automatic fold_space();
    if (field_len >= FoldLimit) return;
    field_len++;
    case (fmode)
      M_NAME, M_NAME_STRIP: begin
        fmode = M_NAME;
        match_char(" ");
        if (fmode == M_NAME) fmode = M_NAME_STRIP;
      end
      M_VALUE, M_VALUE_STRIP: begin
        value_out(" ");
        fmode = M_VALUE_STRIP;
      end
      M_ENVWORD: fmode = M_IGNORE;
      default: ;
    endcase
  endtask

  task automatic field_char(input logic [7:0] c);
    bit blank;
    blank = (c == " " || c == "\t");
    if ((fmode == M_NAME_STRIP || fmode == M_VALUE_STRIP) && blank) return;
    if (field_len >= FoldLimit) return;   // past the fold limit: truncated
    field_len++;
    if (fmode == M_NAME_STRIP)  fmode = M_NAME;
    if (fmode == M_VALUE_STRIP) fmode = M_VALUE;
    case (fmode)
      M_NAME: begin
        if (c == ":") match_colon();
        else match_char(c);
      end
      M_VALSKIP: begin
        if (!blank) begin
          value_out(c);
          fmode = M_VALUE;
        end
      end
      M_VALUE: value_out(c);
      M_ENVSKIP: begin
        if (!blank) begin
          value_out(c);
          fmode = M_ENVWORD;
        end
      end
      M_ENVWORD: begin
        if (c == " ") fmode = M_IGNORE;
        else value_out(c);
      end
      default: ;
    endcase
  endtask

  // Predict the results of one accepted item.
  task automatic parse_item(input cmd_e cmd, input logic [7:0] c);
    bit first;
    if (cmd == CMD_START) begin
      parser_reset();
      return;
    end
    if (cmd == CMD_NOP || hdr_done) return;
    if (cmd == CMD_EOI) begin
      close_field();
      push_result(KIND_HEND, 5'd0, 8'd0);
      hdr_done = 1'b1;
      return;
    end
    if (at_line_start) begin
      first = (fmode == M_NAME) && field_len == 0;
      if (c == "\n") begin
        // empty line ends the header
        close_field();
        push_result(KIND_HEND, 5'd0, 8'd0);
        hdr_done = 1'b1;
        return;
      end
      if (!first && (c == " " || c == "\t")) begin
        // continuation line: joined by one space
        at_line_start = 1'b0;
        line_len = 0;
        fold_space();
        return;
      end
      close_field();
      at_line_start = 1'b0;
      fmode = M_NAME;
      line_len = 0;
    end
    if (c == "\n") begin
      at_line_start = 1'b1;
      return;
    end
    line_len++;
    if (line_len >= MaxLine - 2) begin
      close_field();
      push_result(KIND_HERR, 5'd0, 8'd0);
      hdr_done = 1'b1;
      return;
    end
    field_char(c);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic put_item(input cmd_e cmd, input logic [7:0] d, input bit hold = 1'b0);
    hdr_item_t it;
    it.cmd  = cmd;
    it.data = d;
    it.hold = hold;
    pend_items.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(CMD_DATA, s[i]);
  endtask

  task automatic put_run(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) put_item(CMD_DATA, c);
  endtask

  function automatic logic [7:0] rand_value_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r < 3)  return " ";
    if (r == 3) return "\t";
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic put_value(input int n);
    for (int i = 0; i < n; i++) put_item(CMD_DATA, rand_value_char());
  endtask

  // Known name with random letter case.
  task automatic put_name(input int idx);
    logic [7:0] c;
    for (int i = 0; i < known_tab[idx].len(); i++) begin
      c = known_tab[idx][i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      put_item(CMD_DATA, c);
    end
  endtask

  task automatic put_message();
    int nlines;
    int r;
    put_item(CMD_START, 8'($urandom), $urandom_range(0, 15) == 0);
    nlines = $urandom_range(1, 6);
    for (int l = 0; l < nlines; l++) begin
      r = $urandom_range(0, 11);
      if (r < 6) begin
        put_name($urandom_range(0, NNames - 1));
        put_item(CMD_DATA, ":");
        put_value($urandom_range(0, 16));
      end else if (r == 6) begin
        // name that may or may not be known
        for (int i = $urandom_range(1, 12); i > 0; i--)
          put_item(CMD_DATA, 8'($urandom_range(97, 122)));
        put_item(CMD_DATA, ":");
        put_value($urandom_range(0, 8));
      end else if (r == 7) begin
        put_text("From ");
        put_value($urandom_range(0, 16));
      end else if (r < 10 && l > 0) begin
        put_item(CMD_DATA, $urandom_range(0, 1) ? " " : "\t");
        put_value($urandom_range(0, 12));
      end else begin
        // noise
        for (int i = $urandom_range(1, 8); i > 0; i--)
          put_item(CMD_DATA, 8'($urandom));
        if ($urandom_range(0, 3) == 0) put_item(CMD_NOP, 8'($urandom));
      end
      put_item(CMD_DATA, "\n");
    end
    r = $urandom_range(0, 19);
    if (r < 12) put_item(CMD_DATA, "\n");
    else if (r < 17) put_item(CMD_EOI, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts with random gaps, and hold-offs until results drain
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;
  int drain_wait;

  initial begin
    in_if.valid     = 1'b0;
    in_if.cmd       = CMD_DATA;
    in_if.data_byte = 8'd0;
    out_if.ready    = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.cmd       <= CMD_DATA;
      in_if.data_byte <= 8'd0;
      burst_left = 1;
      gap_left   = 0;
      drain_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_item(cmd_e'(in_if.cmd), in_if.data_byte);
        void'(pend_items.pop_front());
      end
      if (exp_results.size() == 0) drain_wait++;
      else drain_wait = 0;
      if (in_if.valid && !in_if.ready) begin
        // item still offered: hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pend_items.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pend_items[0].hold && drain_wait < 6) begin
        in_if.valid <= 1'b0;
      end else begin
        pend_items[0].hold = 1'b0;
        in_if.valid     <= 1'b1;
        in_if.cmd       <= pend_items[0].cmd;
        in_if.data_byte <= pend_items[0].data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall pattern is redrawn each time stall_phase wraps
  // --------------------------------------------------------------------------
  int stall_pct;
  int stall_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_pct   = 0;
      stall_phase = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (exp_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d index %0d byte %0h",
                     out_if.kind, out_if.field_index, out_if.value_byte);
        end else begin
          want = exp_results.pop_front();
          if (out_if.kind !== want.kind || out_if.field_index !== want.field_index ||
              out_if.value_byte !== want.value_byte) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind %0d index %0d byte %0h, got %0d %0d %0h",
                       want.kind, want.field_index, want.value_byte,
                       out_if.kind, out_if.field_index, out_if.value_byte);
          end
        end
      end
      stall_phase++;
      if (stall_phase >= 300) begin
        stall_phase = 0;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed then random stimulus, then end of run
  // --------------------------------------------------------------------------
  initial begin
    mismatches  = 0;
    idle_cycles = 0;
    parser_reset();

    // leading blank on the first line is a name character
    put_item(CMD_START, 8'd0);
    put_text(" subject:x\n");
    put_text("sUbJeCt:\tHello World\n");
    put_text("To:  a\n\t  b\n");
    put_text("Cc: q\n \t\n");              // blank-only continuation
    put_text("X-Unknown: z\n");
    put_text("Date:   \n");                 // empty value
    put_text("Keywords: a");
    put_item(CMD_DATA, 8'h00);
    put_item(CMD_DATA, 8'hff);
    put_text("\n");
    put_item(CMD_NOP, 8'hff);
    put_text("Content-Transfer-Encoding: 8bit\nSupersedes: <x>\nFrom: me\n");
    put_run("x", 40);                        // long name
    put_text(":v\n");
    put_text("Organization: ");              // fold limit
    put_run("a", 250);
    put_text("\n ");
    put_run("b", 260);
    put_text("\n\n");
    put_text("ignored\n");                   // after the header ended
    put_item(CMD_EOI, 8'd0);
    put_item(CMD_START, 8'd0, 1'b1);
    put_text("From bob@host Mon\n");
    put_text("Summary: ");                   // overlong line
    put_run("c", 505);
    put_item(CMD_START, 8'd0);
    put_text("Approved: y");
    put_item(CMD_EOI, 8'd0);

    while (pend_items.size() < RandItems + 150) put_message();

    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pend_items.size() == 0);
    wait (exp_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && exp_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: mail_header_field_parser_core.f
hw/rtl/mhfp_pkg.sv
hw/rtl/mhfp_if.sv
hw/rtl/mhfp_front.sv
hw/rtl/mhfp_back.sv
hw/rtl/mail_header_field_parser_core.sv
sim/tb.sv
